// ===== src/banked_bus_decoder_top_defines.svh =====
// Assertion macros shared by the banked bus decoder checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BANKED_BUS_DECODER_TOP_DEFINES_SVH
`define BANKED_BUS_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BBD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("banked bus decoder check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BBD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("banked bus decoder check failed");

`endif

// ===== src/bbd_pkg.sv =====
// Package for the banked bus decoder: command and target codes, field widths,
// fixed addresses and the result and state-update structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

   localparam int ADDR_W        = 16;
   localparam int DATA_W        = 8;
   localparam int CMD_W         = 3;
   localparam int TGT_W         = 4;
   localparam int MEM_ADDR_W    = 19;
   localparam int KEYS_W        = 64;
   localparam int CART_OFFSET_W = 14;
   localparam int RAM_OFFSET_W  = 13;
   localparam int REGION_W      = 2;

   // bus commands
   localparam logic [CMD_W-1:0] CMD_MEM_RD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MEM_WR = 3'd1;
   localparam logic [CMD_W-1:0] CMD_IO_RD  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_IO_WR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_KEYS   = 3'd4;

   // decoded targets
   localparam logic [TGT_W-1:0] TGT_BOOT     = 4'd0;
   localparam logic [TGT_W-1:0] TGT_CART     = 4'd1;
   localparam logic [TGT_W-1:0] TGT_RAM      = 4'd2;
   localparam logic [TGT_W-1:0] TGT_LOCAL    = 4'd3;
   localparam logic [TGT_W-1:0] TGT_VDP_DATA = 4'd4;
   localparam logic [TGT_W-1:0] TGT_VDP_CTRL = 4'd5;
   localparam logic [TGT_W-1:0] TGT_VCOUNT   = 4'd6;
   localparam logic [TGT_W-1:0] TGT_HCOUNT   = 4'd7;
   localparam logic [TGT_W-1:0] TGT_PSG      = 4'd8;
   localparam logic [TGT_W-1:0] TGT_UART_CTL = 4'd9;
   localparam logic [TGT_W-1:0] TGT_UART_DAT = 4'd10;
   localparam logic [TGT_W-1:0] TGT_NONE     = 4'd11;

   // mapper registers in the top of the memory map
   localparam logic [ADDR_W-1:0] ADDR_SLOT2   = 16'hFFFF;
   localparam logic [ADDR_W-1:0] ADDR_SLOT1   = 16'hFFFE;
   localparam logic [ADDR_W-1:0] ADDR_SLOT0   = 16'hFFFD;
   localparam logic [ADDR_W-1:0] ADDR_BOOT_OFF = 16'hFFFC;

   // uart ports, visible only with the boot overlay set
   localparam logic [7:0] PORT_UART_CTL = 8'h10;
   localparam logic [7:0] PORT_UART_DAT = 8'h11;

   // io decode on port bits {7, 6, 0}
   localparam logic [2:0] IOSEL_MISC   = 3'b000;
   localparam logic [2:0] IOSEL_REGWR  = 3'b001;
   localparam logic [2:0] IOSEL_CNT_LO = 3'b010;
   localparam logic [2:0] IOSEL_CNT_HI = 3'b011;
   localparam logic [2:0] IOSEL_VDP_LO = 3'b100;
   localparam logic [2:0] IOSEL_VDP_HI = 3'b101;
   localparam logic [2:0] IOSEL_JOY    = 3'b110;
   localparam logic [2:0] IOSEL_REGION = 3'b111;

   localparam logic [DATA_W-1:0] READ_ALL_ONES = 8'hFF;
   localparam logic [5:0]        REGION_FILL   = 6'h3F;

   // joypad keys: bit index into the key matrix (row * 8 + column)
   localparam int KEY_BTN_X = 45;
   localparam int KEY_BTN_Z = 51;
   localparam int KEY_RIGHT = 15;
   localparam int KEY_LEFT  = 22;
   localparam int KEY_DOWN  = 23;
   localparam int KEY_UP    = 14;

   typedef struct packed {
      logic [TGT_W-1:0]      target;
      logic [MEM_ADDR_W-1:0] mem_address;
      logic                  write_strobe;
      logic [DATA_W-1:0]     read_value;
   } bbd_result_type;

   typedef struct packed {
      logic slot0_we;
      logic slot1_we;
      logic slot2_we;
      logic overlay_clr;
      logic region_we;
      logic keys_we;
   } bbd_update_type;

endpackage

`default_nettype wire

// ===== src/banked_bus_decoder_top.sv =====
// Top level of the banked bus decoder: input register, decoder, mapper state
// and result register. Depends on bbd_pkg, bbd_decode and bbd_state.
`timescale 1ns / 1ps
`default_nettype none

// Banked bus decoder. Each req_ transfer is one CPU bus access (memory or io,
// read or write) or a key matrix update; each one produces exactly one rsp_
// transfer, in order. The response names the target device, the physical
// byte address inside boot ROM, cartridge or RAM (zero otherwise), a write
// strobe, and the read byte for accesses answered here (joypad, region bits,
// 0xFF on unused ports, zero past the end of the boot ROM).
// Rate: one transfer per clock while rsp_stall is low. The access lands in the
// input register on its req_ transfer edge, is decoded in one pass of
// combinational logic, and is captured in the result register once that
// register is free, at which point rsp_valid rises.
// Mapper state (three 16K page slots, boot overlay, region bits, key matrix)
// is written on the same edge the item moves into the result register, so the
// very next access already sees the new mapping. req_stall is raised only
// while the input register holds an item and the result register is full and
// stalled. No clearing pass; the block is ready right after reset.
// Reset state: slots 0/1/2 map pages 0/1/2, boot overlay on, region 3,
// all keys released.
module banked_bus_decoder_top #(
   parameter int PAGE_BITS      = 5,
   parameter int BOOT_ROM_BYTES = 16384
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [bbd_pkg::CMD_W-1:0]      req_command,
   input  wire logic [bbd_pkg::ADDR_W-1:0]     req_address,
   input  wire logic [bbd_pkg::DATA_W-1:0]     req_data,
   input  wire logic [bbd_pkg::KEYS_W-1:0]     req_key_matrix,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [bbd_pkg::TGT_W-1:0]      rsp_target,
   output logic      [bbd_pkg::MEM_ADDR_W-1:0] rsp_mem_address,
   output logic                                rsp_write_strobe,
   output logic      [bbd_pkg::DATA_W-1:0]     rsp_read_value
);
   import bbd_pkg::*;

   // input register
   logic                in_valid_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [DATA_W-1:0]   data_ff;
   logic [KEYS_W-1:0]   keys_ff;

   // result register
   logic                out_valid_ff;
   bbd_result_type      result_ff;

   logic                out_free;   // result register can take an item
   logic                advance;    // input register item moves to result
   logic                req_take;   // req_ transfer this cycle

   bbd_result_type      result_in;
   bbd_update_type      update;

   logic [PAGE_BITS-1:0] page_slot0, page_slot1, page_slot2;
   logic                 boot_overlay;
   logic [REGION_W-1:0]  region_code;
   logic [KEYS_W-1:0]    keyboard_rows;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // input register: loads whenever it is empty or draining this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= req_command;
         addr_ff <= req_address;
         data_ff <= req_data;
         keys_ff <= req_key_matrix;
      end
   end

   bbd_decode #(
      .PAGE_BITS      (PAGE_BITS),
      .BOOT_ROM_BYTES (BOOT_ROM_BYTES)
   ) u_decode (
      .command       (cmd_ff),
      .address       (addr_ff),
      .page_slot0    (page_slot0),
      .page_slot1    (page_slot1),
      .page_slot2    (page_slot2),
      .boot_overlay  (boot_overlay),
      .region_code   (region_code),
      .keyboard_rows (keyboard_rows),
      .result        (result_in),
      .update        (update)
   );

   // state commits exactly when the item is handed to the result register
   bbd_state #(
      .PAGE_BITS (PAGE_BITS)
   ) u_state (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .update        (update),
      .data          (data_ff),
      .key_matrix    (keys_ff),
      .page_slot0    (page_slot0),
      .page_slot1    (page_slot1),
      .page_slot2    (page_slot2),
      .boot_overlay  (boot_overlay),
      .region_code   (region_code),
      .keyboard_rows (keyboard_rows)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_target       = result_ff.target;
   assign rsp_mem_address  = result_ff.mem_address;
   assign rsp_write_strobe = result_ff.write_strobe;
   assign rsp_read_value   = result_ff.read_value;

endmodule

`default_nettype wire

// ===== src/bbd_state.sv =====
// Mapper state registers: page slots, boot overlay, region bits, key matrix.
// Depends on bbd_pkg; written by the update flags from bbd_decode.
`timescale 1ns / 1ps
`default_nettype none

module bbd_state #(
   parameter int PAGE_BITS = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire bbd_pkg::bbd_update_type       update,
   input  wire logic [bbd_pkg::DATA_W-1:0]    data,
   input  wire logic [bbd_pkg::KEYS_W-1:0]    key_matrix,
   output logic      [PAGE_BITS-1:0]          page_slot0,
   output logic      [PAGE_BITS-1:0]          page_slot1,
   output logic      [PAGE_BITS-1:0]          page_slot2,
   output logic                               boot_overlay,
   output logic      [bbd_pkg::REGION_W-1:0]  region_code,
   output logic      [bbd_pkg::KEYS_W-1:0]    keyboard_rows
);
   import bbd_pkg::*;

   localparam logic [PAGE_BITS-1:0] SLOT0_RST = PAGE_BITS'(0);
   localparam logic [PAGE_BITS-1:0] SLOT1_RST = PAGE_BITS'(1);
   localparam logic [PAGE_BITS-1:0] SLOT2_RST = PAGE_BITS'(2);

   logic [PAGE_BITS-1:0] slot0_ff, slot1_ff, slot2_ff;
   logic                 overlay_ff;
   logic [REGION_W-1:0]  region_ff;
   logic [KEYS_W-1:0]    keys_ff;
   logic [PAGE_BITS-1:0] page_in;

   assign page_in = data[PAGE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_ff   <= SLOT0_RST;
         slot1_ff   <= SLOT1_RST;
         slot2_ff   <= SLOT2_RST;
         overlay_ff <= 1'b1;
         region_ff  <= 2'b11;
         keys_ff    <= '1;
      end else if (enable) begin
         if (update.slot0_we) begin
            slot0_ff <= page_in;
         end
         if (update.slot1_we) begin
            slot1_ff <= page_in;
         end
         if (update.slot2_we) begin
            slot2_ff <= page_in;
         end
         if (update.overlay_clr) begin
            overlay_ff <= 1'b0;
         end
         if (update.region_we) begin
            region_ff <= {data[7], data[5]};
         end
         if (update.keys_we) begin
            keys_ff <= key_matrix;
         end
      end
   end

   assign page_slot0    = slot0_ff;
   assign page_slot1    = slot1_ff;
   assign page_slot2    = slot2_ff;
   assign boot_overlay  = overlay_ff;
   assign region_code   = region_ff;
   assign keyboard_rows = keys_ff;

endmodule

`default_nettype wire

// ===== src/bbd_decode.sv =====
// Combinational access decoder: target, physical address, strobe, local
// read data and state-update flags. Depends on bbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbd_decode #(
   parameter int PAGE_BITS      = 5,
   parameter int BOOT_ROM_BYTES = 16384
) (
   input  wire logic [bbd_pkg::CMD_W-1:0]    command,
   input  wire logic [bbd_pkg::ADDR_W-1:0]   address,
   input  wire logic [PAGE_BITS-1:0]         page_slot0,
   input  wire logic [PAGE_BITS-1:0]         page_slot1,
   input  wire logic [PAGE_BITS-1:0]         page_slot2,
   input  wire logic                         boot_overlay,
   input  wire logic [bbd_pkg::REGION_W-1:0] region_code,
   input  wire logic [bbd_pkg::KEYS_W-1:0]   keyboard_rows,
   output bbd_pkg::bbd_result_type           result,
   output bbd_pkg::bbd_update_type           update
);
   import bbd_pkg::*;

   localparam logic [ADDR_W:0] BOOT_LIMIT = (ADDR_W + 1)'(BOOT_ROM_BYTES);

   function automatic logic [MEM_ADDR_W-1:0] cart_addr(input logic [PAGE_BITS-1:0] page,
                                                      input logic [ADDR_W-1:0]    addr);
      return (MEM_ADDR_W'(page) << CART_OFFSET_W) | MEM_ADDR_W'(addr[CART_OFFSET_W-1:0]);
   endfunction

   logic [7:0]             port;
   logic [2:0]             io_sel;
   logic                   io_wr;
   logic                   in_low_16k;
   logic [MEM_ADDR_W-1:0]  ram_addr;
   logic [DATA_W-1:0]      joypad;

   assign port       = address[7:0];
   assign io_sel     = {port[7], port[6], port[0]};
   assign io_wr      = (command == CMD_IO_WR);
   assign in_low_16k = (address[15:14] == 2'b00);
   assign ram_addr   = MEM_ADDR_W'(address[RAM_OFFSET_W-1:0]);

   // active-low keys straight through to active-low pad bits
   assign joypad = {2'b11, keyboard_rows[KEY_BTN_X], keyboard_rows[KEY_BTN_Z],
                    keyboard_rows[KEY_RIGHT], keyboard_rows[KEY_LEFT],
                    keyboard_rows[KEY_DOWN], keyboard_rows[KEY_UP]};

   always_comb begin
      result = '{target: TGT_NONE, mem_address: '0, write_strobe: 1'b0, read_value: '0};
      update = '0;

      unique case (command)
         CMD_MEM_RD: begin
            priority if (boot_overlay && in_low_16k) begin
               if ({1'b0, address} < BOOT_LIMIT) begin
                  result.target      = TGT_BOOT;
                  result.mem_address = MEM_ADDR_W'(address);
               end else begin
                  result.target = TGT_LOCAL;
               end
            end else if (address[15:10] == 6'd0) begin
               result.target      = TGT_CART;
               result.mem_address = MEM_ADDR_W'(address);
            end else if (in_low_16k) begin
               result.target      = TGT_CART;
               result.mem_address = cart_addr(page_slot0, address);
            end else if (address[15:14] == 2'b01) begin
               result.target      = TGT_CART;
               result.mem_address = cart_addr(page_slot1, address);
            end else if (address[15:14] == 2'b10) begin
               result.target      = TGT_CART;
               result.mem_address = cart_addr(page_slot2, address);
            end else begin
               result.target      = TGT_RAM;
               result.mem_address = ram_addr;
            end
         end

         CMD_MEM_WR: begin
            if (boot_overlay && address[15:14] == 2'b01) begin
               result.target       = TGT_CART;
               result.mem_address  = cart_addr(page_slot1, address);
               result.write_strobe = 1'b1;
            end
            if (address[15:14] == 2'b11) begin
               result.target       = TGT_RAM;
               result.mem_address  = ram_addr;
               result.write_strobe = 1'b1;
            end
            update.slot2_we    = (address == ADDR_SLOT2);
            update.slot1_we    = (address == ADDR_SLOT1);
            update.slot0_we    = (address == ADDR_SLOT0);
            update.overlay_clr = (address == ADDR_BOOT_OFF);
         end

         CMD_IO_RD, CMD_IO_WR: begin
            if (boot_overlay && (port == PORT_UART_CTL || port == PORT_UART_DAT)) begin
               result.target       = (port == PORT_UART_CTL) ? TGT_UART_CTL : TGT_UART_DAT;
               result.write_strobe = io_wr;
            end else begin
               unique case (io_sel)
                  IOSEL_REGWR: begin
                     if (io_wr) begin
                        update.region_we = 1'b1;
                     end else begin
                        result.target     = TGT_LOCAL;
                        result.read_value = READ_ALL_ONES;
                     end
                  end
                  IOSEL_CNT_LO, IOSEL_CNT_HI: begin
                     if (io_wr) begin
                        result.target       = TGT_PSG;
                        result.write_strobe = 1'b1;
                     end else begin
                        result.target = port[0] ? TGT_HCOUNT : TGT_VCOUNT;
                     end
                  end
                  IOSEL_VDP_LO, IOSEL_VDP_HI: begin
                     result.target       = port[0] ? TGT_VDP_CTRL : TGT_VDP_DATA;
                     result.write_strobe = io_wr;
                  end
                  IOSEL_JOY: begin
                     if (!io_wr) begin
                        result.target     = TGT_LOCAL;
                        result.read_value = joypad;
                     end
                  end
                  IOSEL_REGION: begin
                     if (!io_wr) begin
                        result.target     = TGT_LOCAL;
                        result.read_value = {region_code, REGION_FILL};
                     end
                  end
                  IOSEL_MISC: begin
                     if (!io_wr) begin
                        result.target     = TGT_LOCAL;
                        result.read_value = READ_ALL_ONES;
                     end
                  end
               endcase
            end
         end

         CMD_KEYS: begin
            update.keys_we = 1'b1;
         end

         default: begin
            // unused commands: no target, no state change
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/bbd_checker.sv =====
// Port-level checks for the banked bus decoder, bound to the top level.
// Depends on bbd_pkg and banked_bus_decoder_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "banked_bus_decoder_top_defines.svh"

module bbd_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_stall,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [bbd_pkg::TGT_W-1:0]      rsp_target,
   input  wire logic [bbd_pkg::MEM_ADDR_W-1:0] rsp_mem_address,
   input  wire logic                           rsp_write_strobe,
   input  wire logic [bbd_pkg::DATA_W-1:0]     rsp_read_value
);
   import bbd_pkg::*;

   logic has_mem;
   logic writable;
   logic [$bits(bbd_result_type)-1:0] rsp_fields;

   assign has_mem  = (rsp_target == TGT_BOOT) || (rsp_target == TGT_CART) ||
                     (rsp_target == TGT_RAM);
   assign writable = (rsp_target == TGT_CART) || (rsp_target == TGT_RAM) ||
                     (rsp_target == TGT_PSG) || (rsp_target == TGT_VDP_DATA) ||
                     (rsp_target == TGT_VDP_CTRL) || (rsp_target == TGT_UART_CTL) ||
                     (rsp_target == TGT_UART_DAT);
   assign rsp_fields = {rsp_target, rsp_mem_address, rsp_write_strobe, rsp_read_value};

   // a stalled response holds its item
   `BBD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fields))

   // only memory targets carry a physical address
   `BBD_ASSERT_NOW(a_addr_only_mem, rsp_valid && !has_mem, rsp_mem_address == '0)

   // only locally answered reads carry read data
   `BBD_ASSERT_NOW(a_value_only_local, rsp_valid && rsp_target != TGT_LOCAL, rsp_read_value == '0)

   // strobes never go to read-only or absent targets
   `BBD_ASSERT_NOW(a_strobe_target, rsp_valid && rsp_write_strobe, writable)

   // the request side stalls only behind a stalled response
   `BBD_ASSERT_NOW(a_req_stall_cause, req_stall, rsp_valid && rsp_stall)

endmodule

bind banked_bus_decoder_top bbd_checker u_bbd_checker (.*);

`default_nettype wire
